>>> rtl/tpfe_pkg.sv
`timescale 1ns / 1ps

package tpfe_pkg;

  // Frame geometry
  localparam int MaxFrameBytes = 65536;
  localparam int OffW          = $clog2(MaxFrameBytes);
  // header positions go up to 134, so compares need at least 8 bits
  localparam int CmpW          = (OffW > 9) ? OffW : 9;

  localparam logic [OffW-1:0] OffMax = OffW'(MaxFrameBytes - 1);

  // Byte positions inside the frame
  localparam int IpStart       = 14;
  localparam int IpProtoPos    = IpStart + 9;
  localparam int IpSrcFirstPos = IpStart + 12;
  localparam int IpSrcLastPos  = IpStart + 15;
  localparam int TcpPortsLast  = 3;   // relative to TCP header start
  localparam int TcpDataOffPos = 12;  // relative to TCP header start

  localparam logic [7:0] TcpProtocol  = 8'd6;
  localparam logic [3:0] MinHdrWords  = 4'd5;
  localparam logic [7:0] LowNibble    = 8'h0f;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMatchAddress   = 8'd0,
    CfgAddressMatchOn = 8'd1,
    CfgMatchSrcPort   = 8'd2,
    CfgMatchDstPort   = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] match_address;
    logic        address_match_on;
    logic [15:0] match_source_port;
    logic [15:0] match_dest_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } out_item_t;

endpackage

>>> rtl/tcp_payload_filter_extractor_core.sv
`timescale 1ns / 1ps

// TCP payload extractor. Takes an Ethernet frame one byte per item (frame_end
// on the last byte), assumes IPv4 at byte 14, and passes on every byte from
// the first TCP payload byte to the end of the frame (padding included) when
// the frame is TCP and matches the source address (if enabled), a nonzero
// source port or a nonzero destination port. The real IP header length and
// TCP data offset are used; a header length or data offset below 5 words,
// a non-TCP protocol or a frame that ends early yields nothing. Timing: one
// input register, one result register; an item is accepted every cycle
// unless in_stall_o is high, and its result, if any, goes from the input
// register to the result register. Stall upstream only rises while a payload
// byte is waiting behind a stalled result. Config writes are always ready and
// must only be issued with the block idle.

module tcp_payload_filter_extractor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // frame bytes in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tpfe_pkg::in_item_t            in_data_i,
  // payload bytes out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tpfe_pkg::out_item_t           out_data_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tpfe_pkg::CfgDataW-1:0] cfg_data_i
);
  import tpfe_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;

  logic hit, out_free, step;

  tpfe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tpfe_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .hit_o  (hit)
  );

  // result register can take a new item when empty or draining this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // held item moves on unless it is a payload byte with nowhere to go
  assign step       = in_valid_q && (!hit || out_free);
  assign in_stall_o = in_valid_q && !step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && hit) begin
      out_q.payload_byte <= in_q.frame_byte;
      out_q.payload_end  <= in_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/tpfe_cfg_regs.sv
`timescale 1ns / 1ps

module tpfe_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tpfe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tpfe_pkg::CfgDataW-1:0] cfg_data_i,
  output tpfe_pkg::cfg_t               cfg_o
);
  import tpfe_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMatchAddress:   cfg_d.match_address     = cfg_data_i;
        CfgAddressMatchOn: cfg_d.address_match_on  = cfg_data_i[0];
        CfgMatchSrcPort:   cfg_d.match_source_port = cfg_data_i[15:0];
        CfgMatchDstPort:   cfg_d.match_dest_port   = cfg_data_i[15:0];
        default:           cfg_d = cfg_q;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/tpfe_parser.sv
`timescale 1ns / 1ps

module tpfe_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,   // item leaves the input register
  input  tpfe_pkg::in_item_t item_i,
  input  tpfe_pkg::cfg_t     cfg_i,
  output logic               hit_o     // item is a payload byte to pass on
);
  import tpfe_pkg::*;

  logic [OffW-1:0] off_q, off_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [3:0]      thl_q, thl_d;
  logic            is_tcp_q, is_tcp_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     ports_q, ports_d;
  logic            drop_q, drop_d;

  logic [CmpW-1:0] off_x, tcp_start, payload_start;
  logic [31:0]     ports_sh;
  logic            sel;

  assign off_x         = CmpW'(off_q);
  assign tcp_start     = CmpW'(IpStart) + CmpW'({ihl_q, 2'b00});
  assign payload_start = tcp_start + CmpW'({thl_q, 2'b00});
  assign ports_sh      = {ports_q[23:0], item_i.frame_byte};

  // selection uses the ports including the byte now arriving
  assign sel = (cfg_i.address_match_on && (src_q == cfg_i.match_address))
            || ((cfg_i.match_source_port != '0)
                && (ports_sh[31:16] == cfg_i.match_source_port))
            || ((cfg_i.match_dest_port != '0)
                && (ports_sh[15:0] == cfg_i.match_dest_port));

  always_comb begin
    ihl_d    = ihl_q;
    thl_d    = thl_q;
    is_tcp_d = is_tcp_q;
    src_d    = src_q;
    ports_d  = ports_q;
    drop_d   = drop_q;
    off_d    = off_q;
    hit_o    = 1'b0;

    if (!drop_q) begin
      priority if (off_x == CmpW'(IpStart)) begin
        ihl_d = 4'(item_i.frame_byte & LowNibble);
        if (ihl_d < MinHdrWords) drop_d = 1'b1;
      end else if (off_x == CmpW'(IpProtoPos)) begin
        is_tcp_d = (item_i.frame_byte == TcpProtocol);
        if (!is_tcp_d) drop_d = 1'b1;
      end else if (off_x >= CmpW'(IpSrcFirstPos) && off_x <= CmpW'(IpSrcLastPos)) begin
        src_d = {src_q[23:0], item_i.frame_byte};
      end else if (off_x >= tcp_start && off_x <= tcp_start + CmpW'(TcpPortsLast)) begin
        ports_d = ports_sh;
        if (off_x == tcp_start + CmpW'(TcpPortsLast) && !sel) drop_d = 1'b1;
      end else if (off_x == tcp_start + CmpW'(TcpDataOffPos)) begin
        thl_d = item_i.frame_byte[7:4];
        if (thl_d < MinHdrWords) drop_d = 1'b1;
      end else if (off_x >= payload_start && is_tcp_q) begin
        hit_o = 1'b1;
      end else begin
        hit_o = 1'b0;
      end
    end

    if (item_i.frame_end) begin
      off_d    = '0;
      ihl_d    = MinHdrWords;
      thl_d    = MinHdrWords;
      is_tcp_d = 1'b0;
      src_d    = '0;
      ports_d  = '0;
      drop_d   = 1'b0;
    end else if (off_q != OffMax) begin
      off_d = off_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      ihl_q    <= MinHdrWords;
      thl_q    <= MinHdrWords;
      is_tcp_q <= 1'b0;
      src_q    <= '0;
      ports_q  <= '0;
      drop_q   <= 1'b0;
    end else if (step_i) begin
      off_q    <= off_d;
      ihl_q    <= ihl_d;
      thl_q    <= thl_d;
      is_tcp_q <= is_tcp_d;
      src_q    <= src_d;
      ports_q  <= ports_d;
      drop_q   <= drop_d;
    end
  end

endmodule

>>> rtl/tpfe_checker.sv
`timescale 1ns / 1ps

module tpfe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input tpfe_pkg::out_item_t           out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);
  import tpfe_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // upstream is only held back by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a fresh result comes from an accepted item that passed the input register and then the result register
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input");

  // register writes never wait
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write blocked");

endmodule

bind tcp_payload_filter_extractor_core tpfe_checker u_tpfe_checker (.*);
